/* design/hsv_pkg.sv */
`default_nettype none

package hsv_pkg;

    localparam int COMP_BITS = 8;
    localparam int HUE_BITS  = 15;

    // Hue term 3840*|diff|/delta never exceeds 3840, so 12 quotient bits suffice.
    localparam int HUE_QBITS = 12;
    localparam int DIV_QBITS = (COMP_BITS > HUE_QBITS) ? COMP_BITS : HUE_QBITS;
    localparam int REM_BITS  = COMP_BITS + DIV_QBITS;
    localparam int DIV_STEPS = 4;
    localparam int DIV_STAGES = (DIV_QBITS + DIV_STEPS - 1) / DIV_STEPS;

    // 3840 = 4096 - 256
    localparam int HSECT_SHIFT_HI = 12;
    localparam int HSECT_SHIFT_LO = 8;

    localparam logic [HUE_BITS-1:0] HUE_GREEN_OFS = HUE_BITS'(7680);
    localparam logic [HUE_BITS-1:0] HUE_BLUE_OFS  = HUE_BITS'(15360);
    localparam logic [HUE_BITS-1:0] HUE_WRAP      = HUE_BITS'(23040);

    localparam int IN_DATA_BITS  = ((3 * COMP_BITS + 7) / 8) * 8;
    localparam int OUT_DATA_BITS = ((HUE_BITS + 2 * COMP_BITS + 7) / 8) * 8;

    typedef logic [COMP_BITS-1:0] t_comp;
    typedef logic [REM_BITS-1:0]  t_rem;
    typedef logic [DIV_QBITS-1:0] t_quo;
    typedef logic [HUE_BITS-1:0]  t_hue;

    typedef enum logic [1:0] {
        SECT_RED,
        SECT_GREEN,
        SECT_BLUE
    } t_sector;

    typedef struct packed {
        t_sector sector;
        logic    neg;
        logic    grey;
    } t_tag;

    typedef struct packed {
        t_rem  hnum;
        t_rem  snum;
        t_comp delta;
        t_comp bright;
        t_tag  tag;
    } t_front;

    typedef struct packed {
        t_quo  hq;
        t_quo  sq;
        t_comp bright;
        t_tag  tag;
    } t_divres;

    typedef struct packed {
        t_rem rem;
        logic q;
    } t_dstep;

    // One restoring division step against the divisor scaled by 2^sh.
    function automatic t_dstep div_step(t_rem rem, t_comp div, int sh);
        t_rem   dsh;
        t_dstep res;
        dsh = t_rem'(div) << sh;
        if (rem >= dsh) begin
            res.rem = rem - dsh;
            res.q   = 1'b1;
        end else begin
            res.rem = rem;
            res.q   = 1'b0;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

/* design/hsv_front.sv */
`default_nettype none

module hsv_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    output logic                 o_ready,
    input  wire hsv_pkg::t_comp  i_red,
    input  wire hsv_pkg::t_comp  i_green,
    input  wire hsv_pkg::t_comp  i_blue,
    output logic                 o_valid,
    input  wire logic            i_ready,
    output hsv_pkg::t_front      o_data
);
    import hsv_pkg::*;

    typedef struct packed {
        t_comp   mx;
        t_comp   mn;
        t_comp   mag;
        logic    neg;
        t_sector sector;
    } t_astage;

    t_astage n_a, r_a;
    logic    r_a_valid;
    t_front  n_b, r_b;
    logic    r_b_valid;
    logic    en_a, en_b;

    logic [COMP_BITS:0] diff;
    logic [COMP_BITS:0] diff_abs;
    t_comp              x_op, y_op;
    t_comp              delta;

    assign en_b    = !r_b_valid || i_ready;
    assign en_a    = !r_a_valid || en_b;
    assign o_ready = en_a;
    assign o_valid = r_b_valid;
    assign o_data  = r_b;

    // Stage A: pick the maximum and its sector, the minimum, and the hue difference.
    always_comb begin
        priority if (i_red >= i_green && i_red >= i_blue) begin
            n_a.sector = SECT_RED;
            n_a.mx     = i_red;
            x_op       = i_green;
            y_op       = i_blue;
        end else if (i_green >= i_blue) begin
            n_a.sector = SECT_GREEN;
            n_a.mx     = i_green;
            x_op       = i_blue;
            y_op       = i_red;
        end else begin
            n_a.sector = SECT_BLUE;
            n_a.mx     = i_blue;
            x_op       = i_red;
            y_op       = i_green;
        end

        if (i_red <= i_green && i_red <= i_blue) begin
            n_a.mn = i_red;
        end else if (i_green <= i_blue) begin
            n_a.mn = i_green;
        end else begin
            n_a.mn = i_blue;
        end

        diff     = {1'b0, x_op} - {1'b0, y_op};
        n_a.neg  = diff[COMP_BITS];
        diff_abs = n_a.neg ? (~diff + 1'b1) : diff;
        n_a.mag  = diff_abs[COMP_BITS-1:0];
    end

    // Stage B: delta and the two dividends.
    always_comb begin
        delta          = r_a.mx - r_a.mn;
        n_b.delta      = delta;
        n_b.bright     = r_a.mx;
        n_b.tag.sector = r_a.sector;
        n_b.tag.neg    = r_a.neg;
        n_b.tag.grey   = (delta == '0);
        n_b.hnum       = (t_rem'(r_a.mag) << HSECT_SHIFT_HI)
                       - (t_rem'(r_a.mag) << HSECT_SHIFT_LO);
        n_b.snum       = (t_rem'(delta) << COMP_BITS) - t_rem'(delta);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            if (en_a) begin
                r_a_valid <= i_valid;
            end
            if (en_b) begin
                r_b_valid <= r_a_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_a <= n_a;
        end
        if (en_b) begin
            r_b <= n_b;
        end
    end

endmodule

`default_nettype wire

/* design/hsv_div.sv */
`default_nettype none

module hsv_div (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire hsv_pkg::t_front  i_data,
    output logic                  o_valid,
    input  wire logic             i_ready,
    output hsv_pkg::t_divres      o_data
);
    import hsv_pkg::*;

    typedef struct packed {
        t_rem  hrem;
        t_rem  srem;
        t_quo  hq;
        t_quo  sq;
        t_comp hdiv;
        t_comp sdiv;
        t_tag  tag;
    } t_dstage;

    t_dstage stg_in  [DIV_STAGES];
    t_dstage stg_out [DIV_STAGES];
    t_dstage r_stg   [DIV_STAGES];
    logic    r_valid [DIV_STAGES];
    logic    stg_en  [DIV_STAGES];

    // Both lanes resolve DIV_STEPS quotient bits per stage, MSB first.
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
        if (s == 0) begin : g_first
            assign stg_in[s] = '{hrem: i_data.hnum, srem: i_data.snum,
                                 hq: '0, sq: '0,
                                 hdiv: i_data.delta, sdiv: i_data.bright,
                                 tag: i_data.tag};
        end else begin : g_next
            assign stg_in[s] = r_stg[s-1];
        end

        if (s == DIV_STAGES - 1) begin : g_last_en
            assign stg_en[s] = !r_valid[s] || i_ready;
        end else begin : g_mid_en
            assign stg_en[s] = !r_valid[s] || stg_en[s+1];
        end

        always_comb begin : c_step
            t_dstage cur;
            t_dstep  hst;
            t_dstep  sst;
            int      k;
            cur = stg_in[s];
            hst = '0;
            sst = '0;
            k   = 0;
            for (int j = 0; j < DIV_STEPS; j++) begin
                k = DIV_QBITS - 1 - (s * DIV_STEPS + j);
                if (k >= 0) begin
                    hst      = div_step(cur.hrem, cur.hdiv, k);
                    sst      = div_step(cur.srem, cur.sdiv, k);
                    cur.hrem = hst.rem;
                    cur.srem = sst.rem;
                    cur.hq   = {cur.hq[DIV_QBITS-2:0], hst.q};
                    cur.sq   = {cur.sq[DIV_QBITS-2:0], sst.q};
                end
            end
            stg_out[s] = cur;
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_valid[s] <= 1'b0;
            end else if (stg_en[s]) begin
                if (s == 0) begin
                    r_valid[s] <= i_valid;
                end else begin
                    r_valid[s] <= r_valid[(s == 0) ? 0 : s - 1];
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (stg_en[s]) begin
                r_stg[s] <= stg_out[s];
            end
        end
    end

    assign o_ready       = stg_en[0];
    assign o_valid       = r_valid[DIV_STAGES-1];
    assign o_data.hq     = r_stg[DIV_STAGES-1].hq;
    assign o_data.sq     = r_stg[DIV_STAGES-1].sq;
    assign o_data.bright = r_stg[DIV_STAGES-1].sdiv;
    assign o_data.tag    = r_stg[DIV_STAGES-1].tag;

endmodule

`default_nettype wire

/* design/hsv_back.sv */
`default_nettype none

module hsv_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire hsv_pkg::t_divres  i_data,
    output logic                   o_valid,
    input  wire logic              i_ready,
    output hsv_pkg::t_hue          o_hue,
    output hsv_pkg::t_comp         o_sat,
    output hsv_pkg::t_comp         o_bright,
    output logic                   o_grey
);
    import hsv_pkg::*;

    t_hue  q;
    t_hue  n_hue, r_hue;
    t_comp n_sat, r_sat;
    t_comp r_bright;
    logic  r_grey;
    logic  r_valid;
    logic  en;

    assign en       = !r_valid || i_ready;
    assign o_ready  = en;
    assign o_valid  = r_valid;
    assign o_hue    = r_hue;
    assign o_sat    = r_sat;
    assign o_bright = r_bright;
    assign o_grey   = r_grey;

    // Apply the sector offset and sign; wrap a negative red hue; force hue and saturation to 0 for grey.
    always_comb begin
        q     = HUE_BITS'(i_data.hq);
        n_sat = i_data.sq[COMP_BITS-1:0];
        unique case (i_data.tag.sector)
            SECT_RED: begin
                if (i_data.tag.neg && q != '0) begin
                    n_hue = HUE_WRAP - q;
                end else begin
                    n_hue = q;
                end
            end
            SECT_GREEN: n_hue = i_data.tag.neg ? HUE_GREEN_OFS - q : HUE_GREEN_OFS + q;
            SECT_BLUE:  n_hue = i_data.tag.neg ? HUE_BLUE_OFS - q : HUE_BLUE_OFS + q;
            default:    n_hue = '0;
        endcase
        if (i_data.tag.grey) begin
            n_hue = '0;
            n_sat = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_hue    <= n_hue;
            r_sat    <= n_sat;
            r_bright <= i_data.bright;
            r_grey   <= i_data.tag.grey;
        end
    end

    a_grey_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && r_grey |-> r_hue == '0 && r_sat == '0)
        else $error("grey pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_hue < HUE_WRAP)
        else $error("hue out of range");

    a_sat_colored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid && !r_grey |-> r_sat != '0)
        else $error("colored pixel with zero saturation");

endmodule

`default_nettype wire

/* design/rgb_to_hsv_converter.sv */
`default_nettype none

// RGB to HSV pixel converter. Takes one 8-bit-per-component RGB pixel per clock and returns
// value (largest component), saturation floor(255*delta/max) and hue in 1/64-degree units
// (0..23039), with a grey flag in tuser when all components are equal (hue and saturation
// then 0). Throughput is one pixel per cycle when m_axis_tready does not stall the output; the
// result passes through six register stages: two front stages (max/min/sector, then dividends),
// three restoring-divider stages resolving four quotient bits each for hue and saturation in
// parallel, and one output register. Each stage holds its item under backpressure, so
// s_axis_tready stays high while any stage has a free slot.
module rgb_to_hsv_converter (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    // red, green, blue
    input  wire logic [hsv_pkg::IN_DATA_BITS-1:0]    s_axis_tdata,
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    // hue, saturation, brightness, zero pad
    output logic [hsv_pkg::OUT_DATA_BITS-1:0]        m_axis_tdata,
    // grey_pixel
    output logic                                     m_axis_tuser
);
    import hsv_pkg::*;

    t_front  front_data;
    logic    front_valid, div_ready;
    t_divres div_data;
    logic    div_valid, back_ready;
    t_hue    hue;
    t_comp   sat, bright;

    hsv_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_red   (s_axis_tdata[COMP_BITS-1:0]),
        .i_green (s_axis_tdata[2*COMP_BITS-1:COMP_BITS]),
        .i_blue  (s_axis_tdata[3*COMP_BITS-1:2*COMP_BITS]),
        .o_valid (front_valid),
        .i_ready (div_ready),
        .o_data  (front_data)
    );

    hsv_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (front_valid),
        .o_ready (div_ready),
        .i_data  (front_data),
        .o_valid (div_valid),
        .i_ready (back_ready),
        .o_data  (div_data)
    );

    hsv_back u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (div_valid),
        .o_ready  (back_ready),
        .i_data   (div_data),
        .o_valid  (m_axis_tvalid),
        .i_ready  (m_axis_tready),
        .o_hue    (hue),
        .o_sat    (sat),
        .o_bright (bright),
        .o_grey   (m_axis_tuser)
    );

    assign m_axis_tdata = OUT_DATA_BITS'({bright, sat, hue});

endmodule

`default_nettype wire
